### hdl/masked_expand_load_macros.svh
// assertion macros for the masked expand load block
// expects i_clk and i_rst_n in the scope of each use
`ifndef MASKED_EXPAND_LOAD_MACROS_SVH
`define MASKED_EXPAND_LOAD_MACROS_SVH
`ifndef SYNTHESIS
`define MEL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define MEL_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MEL_ASSERT_IMP(lbl, ante, cons, msg)
`define MEL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### hdl/mel_pkg.sv
// shared constants, codes and types of the masked expand load block
// no dependencies
`default_nettype none

package mel_pkg;

    localparam int LANES      = 8;
    localparam int VALUE_W    = 32;
    localparam int FIFO_DEPTH = 16;
    localparam int MASK_W     = 8;
    localparam int GSIZE_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int QIDX_W     = $clog2(FIFO_DEPTH);
    localparam int POP_W      = $clog2(LANES + 1);
    localparam int LIDX_W     = $clog2(LANES);

    localparam int IN_DATA_W   = VALUE_W + MASK_W + GSIZE_W;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = LANES * VALUE_W + POP_W;
    localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;

    localparam logic MODE_PUSH   = 1'b0;
    localparam logic MODE_EXPAND = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_PUSH_DROP = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic             push;
        logic [POP_W-1:0] pop;
    } t_q_ctrl;

endpackage

`default_nettype wire

### hdl/masked_expand_load.sv
// masked expand load: each input beat is registered in the input stage, then its result
// in the result stage; one beat per cycle while the result side is not stalled, with a
// combinational prefix count and lane crossbar reading the head slots of the source queue
// reset clears the queue fill count and both stage valids; queue contents
// are not cleared and no clearing pass runs
// depends on mel_pkg, mel_srcq and masked_expand_load_macros.svh
`default_nettype none
`include "masked_expand_load_macros.svh"

module masked_expand_load (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // source_value, valid_mask, group_size
    input  wire logic [mel_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // mode
    input  wire logic [0:0]                      i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // lane0_value .. lane7_value, consumed
    output logic [mel_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,
    // status
    output logic [mel_pkg::STATUS_W-1:0]         o_m_axis_tuser
);

    logic                          r_in_valid;
    logic                          r_mode;
    mel_pkg::t_value               r_value;
    logic [mel_pkg::MASK_W-1:0]    r_mask;
    logic [mel_pkg::GSIZE_W-1:0]   r_gsize;

    logic                          r_out_valid;
    mel_pkg::t_value               r_lane [mel_pkg::LANES];
    logic [mel_pkg::POP_W-1:0]     r_consumed;
    mel_pkg::t_status              r_status;

    mel_pkg::t_value               n_lane [mel_pkg::LANES];
    logic [mel_pkg::POP_W-1:0]     n_consumed;
    mel_pkg::t_status              n_status;

    logic                          s_accept;
    logic                          process;
    mel_pkg::t_q_ctrl              q_ctrl;
    mel_pkg::t_value               q_head [mel_pkg::LANES];
    logic [mel_pkg::CNT_W-1:0]     q_count;
    logic [mel_pkg::LANES-1:0]     active;
    logic [mel_pkg::POP_W-1:0]     pre [mel_pkg::LANES+1];
    logic                          underflow;
    logic                          full;

    assign process         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || process;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mode  <= i_s_axis_tuser[0];
            r_value <= i_s_axis_tdata[mel_pkg::VALUE_W-1:0];
            r_mask  <= i_s_axis_tdata[mel_pkg::VALUE_W +: mel_pkg::MASK_W];
            r_gsize <= i_s_axis_tdata[mel_pkg::VALUE_W + mel_pkg::MASK_W +: mel_pkg::GSIZE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_accept) begin
            r_in_valid <= 1'b1;
        end else if (process) begin
            r_in_valid <= 1'b0;
        end
    end

    // prefix count over the active lanes
    always_comb begin
        pre[0] = '0;
        for (int j = 0; j < mel_pkg::LANES; j++) begin
            active[j]  = r_mask[j] && (mel_pkg::GSIZE_W'(j) < r_gsize);
            pre[j + 1] = pre[j] + mel_pkg::POP_W'(active[j]);
        end
    end

    assign underflow = mel_pkg::CNT_W'(pre[mel_pkg::LANES]) > q_count;
    assign full      = q_count == mel_pkg::CNT_W'(mel_pkg::FIFO_DEPTH);

    always_comb begin
        q_ctrl.push = 1'b0;
        q_ctrl.pop  = '0;
        n_consumed  = '0;
        n_status    = mel_pkg::ST_OK;
        for (int j = 0; j < mel_pkg::LANES; j++) begin
            n_lane[j] = '0;
        end
        unique case (r_mode)
            mel_pkg::MODE_PUSH: begin
                if (full) begin
                    n_status = mel_pkg::ST_PUSH_DROP;
                end else begin
                    q_ctrl.push = process;
                end
            end
            mel_pkg::MODE_EXPAND: begin
                if (underflow) begin
                    n_status = mel_pkg::ST_UNDERFLOW;
                end else begin
                    n_consumed = pre[mel_pkg::LANES];
                    q_ctrl.pop = process ? pre[mel_pkg::LANES] : '0;
                    for (int j = 0; j < mel_pkg::LANES; j++) begin
                        if (active[j]) begin
                            n_lane[j] = q_head[pre[j][mel_pkg::LIDX_W-1:0]];
                        end
                    end
                end
            end
            default: begin
                n_status = mel_pkg::ST_OK;
            end
        endcase
    end

    mel_srcq u_srcq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (q_ctrl),
        .i_push_value (r_value),
        .o_head       (q_head),
        .o_count      (q_count)
    );

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_lane     <= n_lane;
            r_consumed <= n_consumed;
            r_status   <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        o_m_axis_tdata = '0;
        for (int j = 0; j < mel_pkg::LANES; j++) begin
            o_m_axis_tdata[j * mel_pkg::VALUE_W +: mel_pkg::VALUE_W] = r_lane[j];
        end
        o_m_axis_tdata[mel_pkg::LANES * mel_pkg::VALUE_W +: mel_pkg::POP_W] = r_consumed;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_status;

    `MEL_ASSERT_IMP(a_underflow_empty, r_out_valid && r_status == mel_pkg::ST_UNDERFLOW, r_consumed == '0, "underflow beat consumed values")
    `MEL_ASSERT_IMP(a_push_no_pop, r_in_valid && r_mode == mel_pkg::MODE_PUSH, q_ctrl.pop == '0, "push beat pops queue")
    `MEL_ASSERT_NXT(a_result_loads, process, r_out_valid, "processed beat lost")

endmodule

`default_nettype wire

### hdl/mel_srcq.sv
// source value queue: head always at slot zero, shifts down on consume
// depends on mel_pkg and masked_expand_load_macros.svh
`default_nettype none
`include "masked_expand_load_macros.svh"

module mel_srcq (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire mel_pkg::t_q_ctrl          i_ctrl,
    input  wire mel_pkg::t_value           i_push_value,
    output mel_pkg::t_value                o_head [mel_pkg::LANES],
    output logic [mel_pkg::CNT_W-1:0]      o_count
);

    mel_pkg::t_value              r_q [mel_pkg::FIFO_DEPTH];
    mel_pkg::t_value              n_q [mel_pkg::FIFO_DEPTH];
    logic [mel_pkg::CNT_W-1:0]    r_count;
    logic [mel_pkg::CNT_W-1:0]    n_count;

    always_comb begin
        n_q     = r_q;
        n_count = r_count;
        if (i_ctrl.push) begin
            n_q[r_count[mel_pkg::QIDX_W-1:0]] = i_push_value;
            n_count = r_count + 1'b1;
        end else begin
            for (int i = 0; i < mel_pkg::FIFO_DEPTH; i++) begin
                for (int k = 1; k <= mel_pkg::LANES; k++) begin
                    if (i_ctrl.pop == mel_pkg::POP_W'(k) && i + k < mel_pkg::FIFO_DEPTH) begin
                        n_q[i] = r_q[i + k];
                    end
                end
            end
            n_count = r_count - mel_pkg::CNT_W'(i_ctrl.pop);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_comb begin
        for (int j = 0; j < mel_pkg::LANES; j++) begin
            o_head[j] = r_q[j];
        end
    end

    assign o_count = r_count;

    `MEL_ASSERT_IMP(a_count_bound, 1'b1, r_count <= mel_pkg::CNT_W'(mel_pkg::FIFO_DEPTH), "queue count over depth")
    `MEL_ASSERT_IMP(a_no_push_full, i_ctrl.push, r_count < mel_pkg::CNT_W'(mel_pkg::FIFO_DEPTH), "push into full queue")
    `MEL_ASSERT_IMP(a_pop_bound, !i_ctrl.push, mel_pkg::CNT_W'(i_ctrl.pop) <= r_count, "pop beyond fill")
    `MEL_ASSERT_NXT(a_push_count, i_ctrl.push, r_count == $past(r_count) + 1'b1, "push count slip")

endmodule

`default_nettype wire

### tb/masked_expand_load_test.sv
// self-checking testbench for masked_expand_load: a stream of push and expand beats
// is predicted against a software copy of the source queue and checked beat by beat
// depends on mel_pkg and the masked_expand_load rtl
`default_nettype none

module masked_expand_load_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_BEATS = 100;

    typedef struct {
        logic                          mode;
        mel_pkg::t_value               value;
        logic [mel_pkg::MASK_W-1:0]    mask;
        logic [mel_pkg::GSIZE_W-1:0]   gsize;
    } t_beat;

    typedef struct {
        mel_pkg::t_value               lane [mel_pkg::LANES];
        logic [mel_pkg::POP_W-1:0]     consumed;
        mel_pkg::t_status              status;
    } t_lanes;

    typedef struct {
        mel_pkg::t_value               slot [mel_pkg::FIFO_DEPTH];
        int                            rd;
        int                            wr;
        int                            fill;
    } t_srcq_model;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               s_valid = 1'b0;
    logic [mel_pkg::IN_TDATA_W-1:0]     s_tdata = '0;
    logic [0:0]                         s_tuser = '0;
    logic                               m_ready = 1'b0;
    logic                               s_ready;
    logic                               m_valid;
    logic [mel_pkg::OUT_TDATA_W-1:0]    m_tdata;
    logic [mel_pkg::STATUS_W-1:0]       m_tuser;

    t_beat       pending_beats [$];
    t_lanes      awaited_lanes [$];
    t_beat       cur_beat;
    t_srcq_model gen_srcq;
    t_srcq_model dut_srcq;
    logic        s_taken = 1'b0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          n_queued = 0;
    int          n_accepted = 0;
    int          mismatches = 0;
    int          cycles = 0;

    masked_expand_load DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        // source_value, valid_mask, group_size
        .i_s_axis_tdata  (s_tdata),
        // mode
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        // lane0_value .. lane7_value, consumed
        .o_m_axis_tdata  (m_tdata),
        // status
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_lanes expand_predict(inout t_srcq_model q, input t_beat b);
        t_lanes r;
        int size;
        int active;
        for (int j = 0; j < mel_pkg::LANES; j++) begin
            r.lane[j] = '0;
        end
        r.consumed = '0;
        r.status = mel_pkg::ST_OK;
        if (b.mode == mel_pkg::MODE_PUSH) begin
            if (q.fill >= mel_pkg::FIFO_DEPTH) begin
                r.status = mel_pkg::ST_PUSH_DROP;
            end else begin
                q.slot[q.wr] = b.value;
                q.wr = (q.wr + 1) % mel_pkg::FIFO_DEPTH;
                q.fill++;
            end
        end else begin
            size = (int'(b.gsize) > mel_pkg::LANES) ? mel_pkg::LANES : int'(b.gsize);
            active = int'(b.mask) & ((1 << size) - 1);
            if ($countones(active) > q.fill) begin
                r.status = mel_pkg::ST_UNDERFLOW;
            end else begin
                for (int j = 0; j < mel_pkg::LANES; j++) begin
                    if (active[j]) begin
                        r.lane[j] = q.slot[q.rd];
                        q.rd = (q.rd + 1) % mel_pkg::FIFO_DEPTH;
                        q.fill--;
                        r.consumed++;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_beat make_beat(logic mode, mel_pkg::t_value value,
                                        logic [mel_pkg::MASK_W-1:0] mask,
                                        logic [mel_pkg::GSIZE_W-1:0] gsize);
        t_beat b;
        b.mode = mode;
        b.value = value;
        b.mask = mask;
        b.gsize = gsize;
        return b;
    endfunction

    // steer the queue fill towards a moving target so both empty and full are reached
    function automatic t_beat random_beat(int target, int fill);
        t_beat b;
        int push_pct;
        b.value = mel_pkg::t_value'($urandom);
        b.mask = mel_pkg::MASK_W'($urandom_range(255));
        if ($urandom_range(99) < 10) begin
            b.mode = 1'($urandom_range(1));
            b.gsize = mel_pkg::GSIZE_W'($urandom_range(15));
        end else begin
            push_pct = (fill <= target) ? 70 : 25;
            b.mode = ($urandom_range(99) < push_pct) ? mel_pkg::MODE_PUSH
                                                     : mel_pkg::MODE_EXPAND;
            b.gsize = mel_pkg::GSIZE_W'($urandom_range(mel_pkg::LANES, 1));
        end
        return b;
    endfunction

    task automatic queue_beat(t_beat b);
        void'(expand_predict(gen_srcq, b));
        pending_beats.push_back(b);
        n_queued++;
    endtask

    task automatic drain;
        while (n_accepted != n_queued || awaited_lanes.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= idle_pct) begin
                cur_beat = pending_beats.pop_front();
                s_valid <= 1'b1;
                s_tdata <= mel_pkg::IN_TDATA_W'({cur_beat.gsize, cur_beat.mask,
                                                 cur_beat.value});
                s_tuser <= cur_beat.mode;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        t_lanes exp_r;
        t_lanes got;
        logic bad;
        s_taken <= i_rst_n && s_valid && s_ready;
        if (i_rst_n && s_valid && s_ready) begin
            awaited_lanes.push_back(expand_predict(dut_srcq, cur_beat));
            n_accepted++;
        end
        if (i_rst_n && m_valid && m_ready) begin
            for (int j = 0; j < mel_pkg::LANES; j++) begin
                got.lane[j] = m_tdata[j*mel_pkg::VALUE_W +: mel_pkg::VALUE_W];
            end
            got.consumed = m_tdata[mel_pkg::LANES*mel_pkg::VALUE_W +: mel_pkg::POP_W];
            got.status = mel_pkg::t_status'(m_tuser);
            if (awaited_lanes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result beat: consumed %0d status %0d",
                             got.consumed, got.status);
                end
            end else begin
                exp_r = awaited_lanes.pop_front();
                bad = (got.consumed !== exp_r.consumed) || (got.status !== exp_r.status);
                for (int j = 0; j < mel_pkg::LANES; j++) begin
                    if (got.lane[j] !== exp_r.lane[j]) begin
                        bad = 1'b1;
                    end
                end
                if (bad) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: consumed %0d/%0d status %0d/%0d (expected/actual)",
                                 exp_r.consumed, got.consumed, exp_r.status, got.status);
                        for (int j = 0; j < mel_pkg::LANES; j++) begin
                            $display("  lane%0d expected %h actual %h", j, exp_r.lane[j],
                                     got.lane[j]);
                        end
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int idle_tab [4];
        int stall_tab [4];
        int target;
        idle_tab = '{0, 72, 0, 19};
        stall_tab = '{0, 0, 72, 19};
        gen_srcq.rd = 0;
        gen_srcq.wr = 0;
        gen_srcq.fill = 0;
        dut_srcq.rd = 0;
        dut_srcq.wr = 0;
        dut_srcq.fill = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, underflow, empty group, full queue and drop, oversized and tail groups
        queue_beat(make_beat(mel_pkg::MODE_PUSH, 32'sh7FFF_FFFF, 8'h00, 4'd0));
        queue_beat(make_beat(mel_pkg::MODE_PUSH, 32'sh8000_0000, 8'hFF, 4'd15));
        queue_beat(make_beat(mel_pkg::MODE_PUSH, 32'shFFFF_FFFF, 8'h5A, 4'd8));
        queue_beat(make_beat(mel_pkg::MODE_PUSH, 32'sh0000_0000, 8'hA5, 4'd1));
        queue_beat(make_beat(mel_pkg::MODE_EXPAND, 32'sh0, 8'hFF, 4'd8));
        queue_beat(make_beat(mel_pkg::MODE_EXPAND, 32'shFFFF_FFFF, 8'hFF, 4'd0));
        for (int i = 0; i < 12; i++) begin
            queue_beat(make_beat(mel_pkg::MODE_PUSH, mel_pkg::t_value'($urandom),
                                 8'h00, 4'd0));
        end
        queue_beat(make_beat(mel_pkg::MODE_PUSH, 32'sh1234_5678, 8'hFF, 4'd8));
        queue_beat(make_beat(mel_pkg::MODE_EXPAND, 32'sh0, 8'hFF, 4'd8));
        queue_beat(make_beat(mel_pkg::MODE_EXPAND, 32'sh0, 8'hA5, 4'd15));
        queue_beat(make_beat(mel_pkg::MODE_EXPAND, 32'sh0, 8'hF0, 4'd5));
        queue_beat(make_beat(mel_pkg::MODE_EXPAND, 32'sh0, 8'h00, 4'd8));

        for (int p = 0; p < 4; p++) begin
            idle_pct = idle_tab[p];
            stall_pct = stall_tab[p];
            target = 8;
            for (int i = 0; i < PHASE_BEATS; i++) begin
                if (i % 40 == 0) begin
                    target = $urandom_range(mel_pkg::FIFO_DEPTH);
                end
                queue_beat(random_beat(target, gen_srcq.fill));
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_lanes.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

### masked_expand_load.f
+incdir+hdl
hdl/mel_pkg.sv
hdl/mel_srcq.sv
hdl/masked_expand_load.sv
tb/masked_expand_load_test.sv
